// File: rtl/rsfd_pkg.sv
// Shared constants, types and queue entry layout for the range step feature detector.
package rsfd_pkg;

  localparam int CHANNELS      = 7;
  localparam int HISTORY_DEPTH = 4;
  localparam int REPEAT_COUNT  = 2;

  // The number of recent readings checked, kept below the history depth so that
  // a reference reading always exists.
  localparam int REPEAT_EFF = (REPEAT_COUNT > HISTORY_DEPTH - 1) ? HISTORY_DEPTH - 1 :
                              ((REPEAT_COUNT < 1) ? 1 : REPEAT_COUNT);

  localparam int CH_W     = 3;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SAMPLE_W = 10;
  localparam int RANGE_W  = 11;
  localparam int CODE_W   = 2;
  localparam int THRESH_W = 10;
  localparam int RISE_W   = SAMPLE_W + 1;
  localparam int SUM_W    = RISE_W + $clog2(REPEAT_EFF) + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = THRESH_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_THRESHOLD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JUNCTION_THRESHOLD = 1'd1;

  localparam logic [THRESH_W-1:0] FEATURE_RESET  = 10'd15;
  localparam logic [THRESH_W-1:0] JUNCTION_RESET = 10'd200;

  localparam logic [RANGE_W-1:0] RANGE_NONE = 11'h7FF;

  typedef enum logic [CODE_W-1:0] {
    CODE_NONE     = 2'd0,
    CODE_OTHER    = 2'd1,
    CODE_JUNCTION = 2'd2
  } feature_code_t;

  // One item as handed from the front to the back. Rises are stored newest first.
  typedef struct packed {
    logic                                report;
    logic [SAMPLE_W-1:0]                 sample;
    logic [REPEAT_EFF-1:0][RISE_W-1:0]   rises;
  } queue_entry_t;

endpackage

// File: rtl/rsfd_front.sv
// Front part: accepts samples, keeps per-channel history and computes the rises.
module rsfd_front import rsfd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CH_W-1:0]     channel,
  input  logic [SAMPLE_W-1:0] sample_cm,
  input  logic                queue_full,
  output logic                push,
  output queue_entry_t        push_entry
);

  logic [HISTORY_DEPTH-1:0][SAMPLE_W-1:0] history [CHANNELS];
  logic [CHANNELS-1:0]                    first_pending;

  logic                                   ch_ok;
  logic [CH_IDX_W-1:0]                    ch_idx;
  logic [HISTORY_DEPTH-1:0][SAMPLE_W-1:0] shifted;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;
  assign ch_ok    = ({1'b0, channel} < (CH_W + 1)'(CHANNELS));
  assign ch_idx   = CH_IDX_W'(channel);

  always_comb begin
    logic [HISTORY_DEPTH-1:0][SAMPLE_W-1:0] cur;
    cur = history[ch_idx];
    for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
      shifted[i] = cur[i + 1];
    end
    shifted[HISTORY_DEPTH - 1] = sample_cm;

    push_entry.report = ch_ok && !first_pending[ch_idx];
    push_entry.sample = sample_cm;
    for (int i = 0; i < REPEAT_EFF; i++) begin
      push_entry.rises[i] = {1'b0, shifted[HISTORY_DEPTH - 1 - i]} -
                            {1'b0, shifted[HISTORY_DEPTH - 1 - REPEAT_EFF]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending <= '1;
    end else if (push && ch_ok) begin
      first_pending[ch_idx] <= 1'b0;
    end
  end

  // A channel's first sample fills its whole history.
  always_ff @(posedge clk) begin
    if (push && ch_ok) begin
      if (first_pending[ch_idx]) begin
        history[ch_idx] <= {HISTORY_DEPTH{sample_cm}};
      end else begin
        history[ch_idx] <= shifted;
      end
    end
  end

endmodule

// File: rtl/rsfd_queue.sv
// Short queue that decouples the front part from the back part.
module rsfd_queue import rsfd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  queue_entry_t push_entry,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output queue_entry_t head_entry
);

  queue_entry_t      mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("item pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> !pop) else $error("item popped from an empty queue");

  a_count_tracks_ptrs: assert property (@(posedge clk) disable iff (rst)
    count[QPTR_W-1:0] == QPTR_W'(wr_ptr - rd_ptr))
    else $error("queue fill count disagrees with pointers");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue fill count did not grow on a push");

endmodule

// File: rtl/rsfd_back.sv
// Back part: holds the thresholds, classifies queued items and drives the result register.
module rsfd_back import rsfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  head_valid,
  input  queue_entry_t          head_entry,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CODE_W-1:0]     feature_code,
  output logic [RANGE_W-1:0]    range_out
);

  logic [THRESH_W-1:0] feature_threshold;
  logic [THRESH_W-1:0] junction_threshold;

  feature_code_t       code_calc;
  feature_code_t       code_reg;
  logic [RANGE_W-1:0]  range_calc;

  always_ff @(posedge clk) begin
    if (rst) begin
      feature_threshold  <= FEATURE_RESET;
      junction_threshold <= JUNCTION_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FEATURE_THRESHOLD:  feature_threshold  <= cfg_data;
        CFG_JUNCTION_THRESHOLD: junction_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] rise_s;
    logic signed [SUM_W-1:0] sum_acc;
    logic signed [SUM_W-1:0] ft_s;
    logic        [SUM_W-1:0] jprod;
    logic                    all_pass;
    ft_s     = $signed({{(SUM_W - THRESH_W){1'b0}}, feature_threshold});
    jprod    = SUM_W'(junction_threshold) * SUM_W'(REPEAT_EFF);
    sum_acc  = '0;
    all_pass = 1'b1;
    for (int i = 0; i < REPEAT_EFF; i++) begin
      rise_s = SUM_W'($signed(head_entry.rises[i]));
      if (rise_s < ft_s) begin
        all_pass = 1'b0;
      end
      sum_acc = sum_acc + rise_s;
    end

    if (!head_entry.report || !all_pass) begin
      code_calc = CODE_NONE;
    end else if (sum_acc >= $signed(jprod)) begin
      code_calc = CODE_JUNCTION;
    end else begin
      code_calc = CODE_OTHER;
    end
    range_calc = head_entry.report ? {1'b0, head_entry.sample} : RANGE_NONE;
  end

  // The result register is refilled whenever it is empty or being taken.
  assign pop = head_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      code_reg  <= code_calc;
      range_out <= range_calc;
    end
  end

  assign feature_code = code_reg;

endmodule

// File: rtl/range_step_feature_detector_top.sv
// Top level of the multi-channel sonar range step feature detector.
//
// Input channel: in_valid/in_ready carry one item, a channel number and a range
// sample in centimetres. Output channel: out_valid/out_ready carry one item per
// input item, in order: a feature code (none, other, junction) and the echoed
// range, or -1 on a channel's first sample or on a channel number out of range.
// The user writes the thresholds through cfg_we, cfg_index and cfg_data only
// while idle; the block itself does not enforce this.
// Throughput is one item per cycle while the queue is not full. When an item is
// accepted, the front part updates the channel history and writes the rises
// into a four-entry queue; the back part then classifies the queue head into
// the result register whenever that register is empty or being taken.
// Reset clears the queue and the result register, marks every channel as not
// yet seen and restores the threshold defaults. History needs no clearing.
// When the receiver stalls, the result register holds and the queue fills;
// in_ready falls only once four items are waiting in the queue.
module range_step_feature_detector_top import rsfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CH_W-1:0]       channel,
  input  logic [SAMPLE_W-1:0]   sample_cm,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CODE_W-1:0]     feature_code,
  output logic [RANGE_W-1:0]    range_out
);

  logic         push;
  logic         pop;
  logic         queue_full;
  logic         head_valid;
  queue_entry_t push_entry;
  queue_entry_t head_entry;

  rsfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .channel    (channel),
    .sample_cm  (sample_cm),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  rsfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  rsfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head_valid   (head_valid),
    .head_entry   (head_entry),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .feature_code (feature_code),
    .range_out    (range_out)
  );

endmodule
